@@ hw/rtl/rbb_pkg.sv @@
// Shared types and constants for the RGB 3x3 box blur.
package rbb_pkg;

   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int ROW_W        = 12;
   localparam int COL_W        = 11;
   localparam int MAX_HEIGHT   = 4096;
   localparam int LANES        = 4;
   localparam int SUM_W        = 12;
   localparam int RECIP_W      = 13;
   localparam int PROD_W       = SUM_W + RECIP_W;

   // floor(x * 7282 / 2**16) == floor(x / 9) for every x below 2**15
   localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;

   // Group queue between the lanes and the output register.
   localparam int GRP_AW    = 3;
   localparam int GRP_DEPTH = 1 << GRP_AW;
   localparam int GRP_CW    = GRP_AW + 1;

   // Register indexes, decoded from csr_paddr[2].
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Window row k, column m holds pixel (r-2+k, c-2+m).
   typedef pixel_type [2:0][2:0] win_type;

   // Bit i of row/col enables window row/column i.
   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } lane_mask_type;

   typedef struct packed {
      logic [LANES-1:0]                lane_valid;
      lane_mask_type [LANES-1:0]       mask;
      logic [ROW_W-1:0]                row;
      logic [COL_W-1:0]                col;
   } item_ctl_type;

   typedef struct packed {
      logic [LANES-1:0]          lane_valid;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      pixel_type [LANES-1:0]     avg;
   } group_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]       avg_red;
      logic [7:0]       avg_green;
      logic [7:0]       avg_blue;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             last;
   } rsp_type;

   // (sum + 4) / 9 by reciprocal multiply
   function automatic logic [7:0] div9_round(input logic [SUM_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'({1'b0, sum} + 13'd4) * PROD_W'(RECIP9);
      return prod[23:16];
   endfunction

endpackage

@@ hw/rtl/rbb_window.sv @@
// Line stores and 3x3 window register of the box blur.
module rbb_window #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart,
   input  logic                         push,
   input  logic [$clog2(MAX_WIDTH)-1:0] push_col,
   input  rbb_pkg::pixel_type           push_px,
   output rbb_pkg::win_type             win
);

   localparam int CW = $clog2(MAX_WIDTH);

   rbb_pkg::pixel_type up_mem  [MAX_WIDTH];
   rbb_pkg::pixel_type mid_mem [MAX_WIDTH];

   logic               s1_valid_ff;
   logic [CW-1:0]      s1_col_ff;
   rbb_pkg::pixel_type s1_px_ff;
   rbb_pkg::pixel_type up_rd_ff;
   rbb_pkg::pixel_type mid_rd_ff;
   rbb_pkg::win_type   window_ff;
   rbb_pkg::win_type   window_in;
   logic               bypass;

   // one-pixel-wide frames read the column being written this cycle
   assign bypass = s1_valid_ff && (s1_col_ff == push_col);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         s1_col_ff <= push_col;
         s1_px_ff  <= push_px;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         up_mem[s1_col_ff]  <= mid_rd_ff;
         mid_mem[s1_col_ff] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         if (bypass) begin
            up_rd_ff  <= mid_rd_ff;
            mid_rd_ff <= s1_px_ff;
         end else begin
            up_rd_ff  <= up_mem[push_col];
            mid_rd_ff <= mid_mem[push_col];
         end
      end
   end

   always_comb begin
      window_in = window_ff;
      for (int m = 0; m < 3; m++) begin
         window_in[m][0] = window_ff[m][1];
         window_in[m][1] = window_ff[m][2];
      end
      window_in[0][2] = up_rd_ff;
      window_in[1][2] = mid_rd_ff;
      window_in[2][2] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         window_ff <= '0;
      end else if (s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   assign win = window_ff;

endmodule

@@ hw/rtl/rbb_lane.sv @@
// One output lane: masked 3x3 sum and divide by nine, two stages.
module rbb_lane (
   input  logic                   clock,
   input  rbb_pkg::win_type       win,
   input  rbb_pkg::lane_mask_type mask,
   output rbb_pkg::pixel_type     avg
);

   logic [rbb_pkg::SUM_W-1:0] row_r [3];
   logic [rbb_pkg::SUM_W-1:0] row_g [3];
   logic [rbb_pkg::SUM_W-1:0] row_b [3];
   logic [rbb_pkg::SUM_W-1:0] sum_r_in, sum_g_in, sum_b_in;
   logic [rbb_pkg::SUM_W-1:0] sum_r_ff, sum_g_ff, sum_b_ff;
   rbb_pkg::pixel_type        avg_in;
   rbb_pkg::pixel_type        avg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         row_r[i] = '0;
         row_g[i] = '0;
         row_b[i] = '0;
         for (int j = 0; j < 3; j++) begin
            if (mask.row[i] && mask.col[j]) begin
               row_r[i] = row_r[i] + rbb_pkg::SUM_W'(win[i][j].red);
               row_g[i] = row_g[i] + rbb_pkg::SUM_W'(win[i][j].green);
               row_b[i] = row_b[i] + rbb_pkg::SUM_W'(win[i][j].blue);
            end
         end
      end
      sum_r_in = row_r[0] + row_r[1] + row_r[2];
      sum_g_in = row_g[0] + row_g[1] + row_g[2];
      sum_b_in = row_b[0] + row_b[1] + row_b[2];
   end

   always_ff @(posedge clock) begin
      sum_r_ff <= sum_r_in;
      sum_g_ff <= sum_g_in;
      sum_b_ff <= sum_b_in;
   end

   always_comb begin
      avg_in.red   = rbb_pkg::div9_round(sum_r_ff);
      avg_in.green = rbb_pkg::div9_round(sum_g_ff);
      avg_in.blue  = rbb_pkg::div9_round(sum_b_ff);
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
   end

   assign avg = avg_ff;

endmodule

@@ hw/rtl/rbb_merge.sv @@
// Group queue and output register: serializes up to four lane results per pixel.
module rbb_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rbb_pkg::group_type push_grp,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rbb_pkg::rsp_type   rsp_data
);

   rbb_pkg::group_type              fifo_ff [rbb_pkg::GRP_DEPTH];
   logic [rbb_pkg::GRP_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [rbb_pkg::GRP_CW-1:0]      cnt_ff, cnt_in;
   logic [rbb_pkg::LANES-1:0]       taken_ff;
   logic                            out_valid_ff;
   rbb_pkg::rsp_type                out_data_ff;

   rbb_pkg::group_type              head;
   logic [rbb_pkg::LANES-1:0]       rem, sel;
   logic [1:0]                      idx;
   logic                            nonempty, load, more;
   rbb_pkg::rsp_type                out_in;

   assign head     = fifo_ff[rd_ptr_ff];
   assign rem      = head.lane_valid & ~taken_ff;
   assign nonempty = (cnt_ff != '0);

   always_comb begin
      priority if (rem[0]) begin
         idx = 2'd0;
      end else if (rem[1]) begin
         idx = 2'd1;
      end else if (rem[2]) begin
         idx = 2'd2;
      end else begin
         idx = 2'd3;
      end
   end

   assign sel  = rbb_pkg::LANES'(1) << idx;
   assign more = |(rem & ~sel);
   assign load = nonempty && (!out_valid_ff || !rsp_stall);
   assign pop  = load && !more;

   // lanes 0/1 sit one row up, lanes 0/2 one column left
   always_comb begin
      out_in.avg_red   = head.avg[idx].red;
      out_in.avg_green = head.avg[idx].green;
      out_in.avg_blue  = head.avg[idx].blue;
      out_in.out_row   = head.row - {{(rbb_pkg::ROW_W-1){1'b0}}, ~idx[1]};
      out_in.out_col   = head.col - {{(rbb_pkg::COL_W-1){1'b0}}, ~idx[0]};
      out_in.last      = !more;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_grp;
      end
   end

   assign cnt_in = cnt_ff + rbb_pkg::GRP_CW'(push) - rbb_pkg::GRP_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         taken_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
            taken_ff  <= '0;
         end else if (load) begin
            taken_ff  <= taken_ff | sel;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ hw/rtl/rgb_box_blur_3x3.sv @@
// Top level of the streaming RGB 3x3 box blur.
//
//  port group   direction  handshake              payload
//  req_*        in         req_valid / req_stall  req_data  (rbb_pkg::req_type)
//  rsp_*        out        rsp_valid / rsp_stall  rsp_data  (rbb_pkg::rsp_type)
//  csr_*        in/out     APB r/w,   pready = 1  frame_width @0x0, frame_height @0x4
//
//  One pixel request per clock while req_stall is low. Four lanes compute the four
//  possible results of a pixel at once; the output register drains them one per clock
//  while rsp_stall is low; last row/column pixels (up to 4 results) can stall input.
//  req_stall rises once 8 pixels with pending results sit in the pipeline or group queue.
//  Synchronous reset: 640 x 480, counters and window cleared; line stores need no clearing.
//  A register write restarts the frame.
module rgb_box_blur_3x3 #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rbb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbb_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > rbb_pkg::CFG_WIDTH_W) ? CW + 1 : rbb_pkg::CFG_WIDTH_W;

   logic [rbb_pkg::CFG_WIDTH_W-1:0]  frame_width_ff;
   logic [rbb_pkg::CFG_HEIGHT_W-1:0] frame_height_ff;
   logic                             csr_wr;

   logic [EW-1:0]                    w_ext, w_eff;
   logic [rbb_pkg::CFG_HEIGHT_W-1:0] h_eff;
   logic [CW-1:0]                    last_col;
   logic [rbb_pkg::ROW_W-1:0]        last_row;

   logic [CW-1:0]                    col_ff;
   logic [rbb_pkg::ROW_W-1:0]        row_ff;
   logic                             accept;
   logic                             c_last, r_last, c_ge1, c_ge2, r_ge1, r_ge2;
   rbb_pkg::item_ctl_type            ctl_in;

   logic [4:1]                       s_valid_ff;
   rbb_pkg::item_ctl_type            s_ctl_ff [4:1];

   logic [rbb_pkg::GRP_CW-1:0]       grp_cnt_ff, grp_cnt_in;
   logic                             grp_push, grp_pop;
   rbb_pkg::group_type               grp;
   rbb_pkg::win_type                 win;
   rbb_pkg::pixel_type               lane_avg [rbb_pkg::LANES];
   rbb_pkg::pixel_type               in_px;

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 12'd640;
         frame_height_ff <= 13'd480;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            rbb_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_pwdata[rbb_pkg::CFG_WIDTH_W-1:0];
            end
            rbb_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_pwdata[rbb_pkg::CFG_HEIGHT_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         rbb_pkg::REG_FRAME_WIDTH: begin
            csr_prdata = 32'(frame_width_ff);
         end
         rbb_pkg::REG_FRAME_HEIGHT: begin
            csr_prdata = 32'(frame_height_ff);
         end
      endcase
   end

   // zero acts as one, oversize clamps
   always_comb begin
      w_ext = EW'(frame_width_ff);
      if (frame_width_ff == '0) begin
         w_eff = EW'(1);
      end else if (w_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      if (frame_height_ff == '0) begin
         h_eff = rbb_pkg::CFG_HEIGHT_W'(1);
      end else if (frame_height_ff > rbb_pkg::CFG_HEIGHT_W'(rbb_pkg::MAX_HEIGHT)) begin
         h_eff = rbb_pkg::CFG_HEIGHT_W'(rbb_pkg::MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   assign last_col = CW'(w_eff - EW'(1));
   assign last_row = rbb_pkg::ROW_W'(h_eff - rbb_pkg::CFG_HEIGHT_W'(1));

   // ---- request side ----
   assign req_stall = (grp_cnt_ff == rbb_pkg::GRP_CW'(rbb_pkg::GRP_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign c_last = (col_ff == last_col);
   assign r_last = (row_ff == last_row);
   assign c_ge1  = (col_ff != '0);
   assign c_ge2  = (col_ff > CW'(1));
   assign r_ge1  = (row_ff != '0);
   assign r_ge2  = (row_ff > rbb_pkg::ROW_W'(1));

   // lane 0: (r-1,c-1)  lane 1: (r-1,c)  lane 2: (r,c-1)  lane 3: (r,c)
   always_comb begin
      ctl_in.lane_valid[0] = r_ge1 && c_ge1;
      ctl_in.lane_valid[1] = r_ge1 && c_last;
      ctl_in.lane_valid[2] = r_last && c_ge1;
      ctl_in.lane_valid[3] = r_last && c_last;
      for (int k = 0; k < rbb_pkg::LANES; k++) begin
         ctl_in.mask[k].row = (k < 2) ? {1'b1, r_ge1, r_ge2} : {1'b1, r_ge1, 1'b0};
         ctl_in.mask[k].col = (k % 2 == 0) ? {1'b1, c_ge1, c_ge2} : {1'b1, c_ge1, 1'b0};
      end
      ctl_in.row = row_ff;
      ctl_in.col = rbb_pkg::COL_W'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (c_last) begin
            col_ff <= '0;
            row_ff <= r_last ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // ---- control pipeline alongside window and lanes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= '0;
      end else begin
         s_valid_ff <= {s_valid_ff[3:1], accept};
      end
   end

   always_ff @(posedge clock) begin
      s_ctl_ff[1] <= ctl_in;
      s_ctl_ff[2] <= s_ctl_ff[1];
      s_ctl_ff[3] <= s_ctl_ff[2];
      s_ctl_ff[4] <= s_ctl_ff[3];
   end

   assign in_px.red   = req_data.in_red;
   assign in_px.green = req_data.in_green;
   assign in_px.blue  = req_data.in_blue;

   rbb_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_wr),
      .push     (accept),
      .push_col (col_ff),
      .push_px  (in_px),
      .win      (win)
   );

   for (genvar k = 0; k < rbb_pkg::LANES; k++) begin : g_lane
      rbb_lane u_lane (
         .clock (clock),
         .win   (win),
         .mask  (s_ctl_ff[2].mask[k]),
         .avg   (lane_avg[k])
      );
   end

   // ---- merge ----
   always_comb begin
      grp.lane_valid = s_ctl_ff[4].lane_valid;
      grp.row        = s_ctl_ff[4].row;
      grp.col        = s_ctl_ff[4].col;
      for (int k = 0; k < rbb_pkg::LANES; k++) begin
         grp.avg[k] = lane_avg[k];
      end
   end

   assign grp_push = s_valid_ff[4] && (|s_ctl_ff[4].lane_valid);

   rbb_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_grp  (grp),
      .pop       (grp_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // credits count pixels with results from request until their group leaves the queue
   assign grp_cnt_in = grp_cnt_ff
                     + rbb_pkg::GRP_CW'(accept && (|ctl_in.lane_valid))
                     - rbb_pkg::GRP_CW'(grp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff <= '0;
      end else begin
         grp_cnt_ff <= grp_cnt_in;
      end
   end

   // ---- assertions ----
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      grp_cnt_ff <= rbb_pkg::GRP_CW'(rbb_pkg::GRP_DEPTH))
      else $error("group credit count above queue depth");

   a_push_reserved: assert property (@(posedge clock) disable iff (reset)
      grp_push |-> grp_cnt_ff != '0)
      else $error("group pushed without a reserved credit");

   a_pop_reserved: assert property (@(posedge clock) disable iff (reset)
      grp_pop |-> grp_cnt_ff != '0)
      else $error("group popped with no credit outstanding");

   a_counters_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= last_col) && (row_ff <= last_row))
      else $error("pixel position outside the configured frame");

endmodule
